// ===== hdl/rmii_pkg.sv =====
package rmii_pkg;

   localparam int BINS = 10;
   localparam int BIN_IDX_W = 4;
   localparam int POS_W = 16;
   localparam int SPEED_W = 10;
   localparam int VAL_W = 16;
   localparam int PITCH_W = 9;
   localparam int CEN_W = 17;
   localparam int PROD_W = 33;
   localparam int CROW_W = 6;

   localparam logic [CEN_W-1:0] CENTRE_BASE = 17'd1200;
   localparam int BIN_SPAN = 100;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 10'd1000;
   localparam logic [PITCH_W-1:0] PITCH_RESET = 9'd200;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_ENABLE = 1'b0,
      CSR_PITCH  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RSCAN,
      S_INS_RD,
      S_INS_CMP,
      S_INS_FILL,
      S_RSEL,
      S_BRD,
      S_BCHK,
      S_BEND,
      S_RDONE,
      S_MUL,
      S_DIV,
      S_ADD,
      S_DONE
   } state_type;

endpackage

// ===== hdl/ramp_map_insert_interpolate.sv =====
// Ramp calibration map with insert, clear and two-dimensional interpolated lookup.
// A command is taken when start is high and busy is low; exactly one result beat
// follows, shown for one cycle with rsp_strobe, and the receiver cannot stall it.
// All work runs on one sequencer with a value memory of one write port and one
// registered read port, one multiplier and one radix-2 divider. A clear, an
// unknown command, a disabled block or a speed outside the bins goes straight to
// the result beat. An insert scans the rows, then reads, compares and rewrites one
// bin or, on a row's first bin write, fills all ten bins of that row. A lookup runs
// the row scan, up to two bin scans and up to three multiply and divide passes.
// Reset empties the map at once through per-row fill flags.
module ramp_map_insert_interpolate #(
   parameter int ROWS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_command,
   input  logic [rmii_pkg::POS_W-1:0]         req_position,
   input  logic [rmii_pkg::SPEED_W-1:0]       req_speed,
   input  logic [rmii_pkg::VAL_W-1:0]         req_ramp_value,
   output logic                               rsp_strobe,
   output logic                               rsp_ok,
   output logic                               rsp_row_changed,
   output logic [rmii_pkg::CROW_W-1:0]        rsp_changed_row,
   output logic [rmii_pkg::VAL_W-1:0]         rsp_ramp_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [rmii_pkg::PITCH_W-1:0]       csr_wdata
);

   localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DEPTH = ROWS * rmii_pkg::BINS;
   localparam int AW = $clog2(DEPTH);
   localparam int CEN_W = rmii_pkg::CEN_W;
   localparam int VAL_W = rmii_pkg::VAL_W;
   localparam int BW = rmii_pkg::BIN_IDX_W;
   localparam int PW = rmii_pkg::PROD_W;

   rmii_pkg::state_type state_ff, state_in;

   logic                          enable_ff;
   logic [rmii_pkg::PITCH_W-1:0]  pitch_ff;
   logic [ROWS-1:0]               nz_ff;
   logic [VAL_W-1:0]              mem_ff [DEPTH];
   logic [VAL_W-1:0]              rd_ff;

   logic [1:0]        cmd_ff;
   logic [CEN_W-1:0]  pos_ff;
   logic [BW-1:0]     tgt_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [RIW-1:0]    row_ff;
   logic [CEN_W-1:0]  cen_ff;

   logic              past_ff, lo_v_ff, hi_v_ff, hit_v_ff, both_ff, pass_ff;
   logic [RIW-1:0]    lo_row_ff, hi_row_ff, hit_row_ff, rl_row_ff;
   logic [CEN_W-1:0]  c_lo_ff, c_hi_ff, tpos_ff;

   logic [BW-1:0]     bin_ff, blo_bin_ff, bhi_bin_ff;
   logic              bpast_ff;
   logic [VAL_W-1:0]  blo_ff, bhi_ff, bhit_ff, rv_ff, a_ff;

   logic              lvl_ff, neg_ff;
   logic [CEN_W-1:0]  opm_ff, div_ff;
   logic [VAL_W-1:0]  opd_ff, base_ff;
   logic [PW-1:0]     quo_ff;
   logic [CEN_W-1:0]  rem_ff;
   logic [5:0]        cnt_ff;

   logic                         ok_ff, chg_ff;
   logic [rmii_pkg::CROW_W-1:0]  crow_ff;
   logic [VAL_W-1:0]             rout_ff;

   logic              accept, spd_ok, go_scan;
   logic [BW-1:0]     tgt_in;
   logic [CEN_W-1:0]  half, lo_edge, hi_edge;
   logic              nz, last, in_row, ins_match, lk_stop;
   logic              rnz, bin_last, b_stop;
   logic [CEN_W:0]    rem_sh;
   logic              rem_ge;
   logic [VAL_W-1:0]  add_res;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [VAL_W-1:0]  mem_wdata;

   assign accept = start && !busy;
   assign csr_ready = 1'b1;
   assign spd_ok = (req_speed != '0) && (req_speed <= rmii_pkg::SPEED_MAX);
   assign go_scan = enable_ff && spd_ok
                    && (req_command == rmii_pkg::CMD_INSERT
                        || req_command == rmii_pkg::CMD_LOOKUP);

   always_comb begin
      tgt_in = '0;
      for (int k = 1; k < rmii_pkg::BINS; k++) begin
         if (req_speed > rmii_pkg::SPEED_W'(k * rmii_pkg::BIN_SPAN)) begin
            tgt_in = tgt_in + 1'b1;
         end
      end
   end

   assign half = CEN_W'(pitch_ff[rmii_pkg::PITCH_W-1:1]);
   assign lo_edge = cen_ff - half;
   assign hi_edge = cen_ff + half;
   assign nz = nz_ff[row_ff];
   assign last = (row_ff == RIW'(ROWS - 1));
   assign in_row = (lo_edge < pos_ff) && (hi_edge >= pos_ff);
   assign ins_match = in_row || ((row_ff == '0) && (lo_edge >= pos_ff))
                      || (last && (hi_edge <= pos_ff));
   assign lk_stop = (nz && !past_ff && (cen_ff >= pos_ff)) || (nz && past_ff) || last;

   assign rnz = (rd_ff != '0);
   assign bin_last = (bin_ff == BW'(rmii_pkg::BINS - 1));
   assign b_stop = (rnz && bpast_ff) || bin_last;

   assign rem_sh = {rem_ff, quo_ff[PW-1]};
   assign rem_ge = (rem_sh >= {1'b0, div_ff});
   assign add_res = neg_ff ? (base_ff - quo_ff[VAL_W-1:0]) : (base_ff + quo_ff[VAL_W-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmii_pkg::S_IDLE: begin
            if (accept) begin
               state_in = go_scan ? rmii_pkg::S_RSCAN : rmii_pkg::S_DONE;
            end
         end
         rmii_pkg::S_RSCAN: begin
            if (cmd_ff == rmii_pkg::CMD_INSERT) begin
               if (ins_match) begin
                  state_in = nz ? rmii_pkg::S_INS_RD : rmii_pkg::S_INS_FILL;
               end else if (last) begin
                  state_in = rmii_pkg::S_DONE;
               end
            end else if (lk_stop) begin
               state_in = rmii_pkg::S_RSEL;
            end
         end
         rmii_pkg::S_INS_RD:   state_in = rmii_pkg::S_INS_CMP;
         rmii_pkg::S_INS_CMP:  state_in = rmii_pkg::S_DONE;
         rmii_pkg::S_INS_FILL: begin
            if (bin_last) begin
               state_in = rmii_pkg::S_DONE;
            end
         end
         rmii_pkg::S_RSEL: begin
            if (!hit_v_ff && !lo_v_ff && !hi_v_ff) begin
               state_in = rmii_pkg::S_DONE;
            end else begin
               state_in = rmii_pkg::S_BRD;
            end
         end
         rmii_pkg::S_BRD:  state_in = rmii_pkg::S_BCHK;
         rmii_pkg::S_BCHK: state_in = b_stop ? rmii_pkg::S_BEND : rmii_pkg::S_BRD;
         rmii_pkg::S_BEND: begin
            if (bhit_ff == '0 && blo_ff != '0 && bhi_ff != '0) begin
               state_in = rmii_pkg::S_MUL;
            end else begin
               state_in = rmii_pkg::S_RDONE;
            end
         end
         rmii_pkg::S_RDONE: begin
            if (both_ff && !pass_ff) begin
               state_in = rmii_pkg::S_BRD;
            end else if (both_ff) begin
               state_in = rmii_pkg::S_MUL;
            end else begin
               state_in = rmii_pkg::S_DONE;
            end
         end
         rmii_pkg::S_MUL: state_in = (div_ff == '0) ? rmii_pkg::S_ADD : rmii_pkg::S_DIV;
         rmii_pkg::S_DIV: begin
            if (cnt_ff == 6'd1) begin
               state_in = rmii_pkg::S_ADD;
            end
         end
         rmii_pkg::S_ADD:  state_in = lvl_ff ? rmii_pkg::S_DONE : rmii_pkg::S_RDONE;
         rmii_pkg::S_DONE: state_in = rmii_pkg::S_IDLE;
         default:          state_in = rmii_pkg::S_IDLE;
      endcase
   end

   // Outputs and memory control.
   always_comb begin
      busy = (state_ff != rmii_pkg::S_IDLE);
      rsp_strobe = (state_ff == rmii_pkg::S_DONE);
      mem_we = 1'b0;
      mem_waddr = AW'(row_ff) * AW'(rmii_pkg::BINS) + AW'(tgt_ff);
      mem_wdata = val_ff;
      mem_raddr = AW'(rl_row_ff) * AW'(rmii_pkg::BINS) + AW'(bin_ff);
      case (state_ff)
         rmii_pkg::S_INS_RD: begin
            mem_raddr = AW'(row_ff) * AW'(rmii_pkg::BINS) + AW'(tgt_ff);
         end
         rmii_pkg::S_INS_CMP: begin
            mem_we = (rd_ff != val_ff);
         end
         rmii_pkg::S_INS_FILL: begin
            mem_we = 1'b1;
            mem_waddr = AW'(row_ff) * AW'(rmii_pkg::BINS) + AW'(bin_ff);
            mem_wdata = (bin_ff == tgt_ff) ? val_ff : '0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign rsp_ok = ok_ff;
   assign rsp_row_changed = chg_ff;
   assign rsp_changed_row = crow_ff;
   assign rsp_ramp_out = rout_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmii_pkg::S_IDLE;
         enable_ff <= 1'b0;
         pitch_ff <= rmii_pkg::PITCH_RESET;
         nz_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rmii_pkg::CSR_ENABLE: enable_ff <= csr_wdata[0];
               rmii_pkg::CSR_PITCH:  pitch_ff <= csr_wdata;
               default:              pitch_ff <= pitch_ff;
            endcase
         end
         if (accept && enable_ff && req_command == rmii_pkg::CMD_CLEAR) begin
            nz_ff <= '0;
         end
         if (state_ff == rmii_pkg::S_INS_FILL && bin_last) begin
            nz_ff[row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rmii_pkg::S_IDLE: begin
            if (accept) begin
               cmd_ff <= req_command;
               pos_ff <= CEN_W'(req_position);
               tgt_ff <= tgt_in;
               val_ff <= req_ramp_value;
               row_ff <= '0;
               cen_ff <= rmii_pkg::CENTRE_BASE;
               past_ff <= 1'b0;
               lo_v_ff <= 1'b0;
               hi_v_ff <= 1'b0;
               hit_v_ff <= 1'b0;
               bin_ff <= '0;
               ok_ff <= 1'b0;
               chg_ff <= 1'b0;
               crow_ff <= '0;
               rout_ff <= '0;
            end
         end
         rmii_pkg::S_RSCAN: begin
            if (cmd_ff == rmii_pkg::CMD_LOOKUP) begin
               if (nz && !past_ff) begin
                  lo_v_ff <= 1'b1;
                  lo_row_ff <= row_ff;
                  c_lo_ff <= cen_ff;
               end
               if (nz && !past_ff && (cen_ff >= pos_ff)) begin
                  past_ff <= past_ff;
               end else if (nz && past_ff) begin
                  hi_v_ff <= 1'b1;
                  hi_row_ff <= row_ff;
                  c_hi_ff <= cen_ff;
               end else if (in_row) begin
                  tpos_ff <= cen_ff;
                  past_ff <= 1'b1;
                  if (nz) begin
                     hit_v_ff <= 1'b1;
                     hit_row_ff <= row_ff;
                  end
               end
            end
            if (!(cmd_ff == rmii_pkg::CMD_INSERT && ins_match) && !last) begin
               row_ff <= row_ff + 1'b1;
               cen_ff <= cen_ff + CEN_W'(pitch_ff);
            end
         end
         rmii_pkg::S_INS_CMP: begin
            ok_ff <= 1'b1;
            if (rd_ff != val_ff) begin
               chg_ff <= 1'b1;
               crow_ff <= rmii_pkg::CROW_W'(row_ff);
            end
         end
         rmii_pkg::S_INS_FILL: begin
            bin_ff <= bin_ff + 1'b1;
            if (bin_last) begin
               ok_ff <= 1'b1;
               if (val_ff != '0) begin
                  chg_ff <= 1'b1;
                  crow_ff <= rmii_pkg::CROW_W'(row_ff);
               end
            end
         end
         rmii_pkg::S_RSEL: begin
            pass_ff <= 1'b0;
            both_ff <= !hit_v_ff && lo_v_ff && hi_v_ff;
            rl_row_ff <= hit_v_ff ? hit_row_ff : (lo_v_ff ? lo_row_ff : hi_row_ff);
            bin_ff <= '0;
            bpast_ff <= 1'b0;
            blo_ff <= '0;
            bhi_ff <= '0;
            bhit_ff <= '0;
            blo_bin_ff <= '0;
            bhi_bin_ff <= '0;
         end
         rmii_pkg::S_BCHK: begin
            if (rnz && !bpast_ff) begin
               blo_ff <= rd_ff;
               blo_bin_ff <= bin_ff;
            end
            if (rnz && bpast_ff) begin
               bhi_ff <= rd_ff;
               bhi_bin_ff <= bin_ff;
            end else if (bin_ff == tgt_ff) begin
               bpast_ff <= 1'b1;
               if (rnz) begin
                  bhit_ff <= rd_ff;
               end
            end
            if (!b_stop) begin
               bin_ff <= bin_ff + 1'b1;
            end
         end
         rmii_pkg::S_BEND: begin
            lvl_ff <= 1'b0;
            opm_ff <= CEN_W'(tgt_ff - blo_bin_ff);
            opd_ff <= (bhi_ff >= blo_ff) ? (bhi_ff - blo_ff) : (blo_ff - bhi_ff);
            neg_ff <= (bhi_ff < blo_ff);
            base_ff <= blo_ff;
            div_ff <= CEN_W'(bhi_bin_ff - blo_bin_ff);
            if (bhit_ff != '0) begin
               rv_ff <= bhit_ff;
            end else if (blo_ff != '0) begin
               rv_ff <= blo_ff;
            end else begin
               rv_ff <= bhi_ff;
            end
         end
         rmii_pkg::S_RDONE: begin
            if (both_ff && !pass_ff) begin
               a_ff <= rv_ff;
               pass_ff <= 1'b1;
               rl_row_ff <= hi_row_ff;
               bin_ff <= '0;
               bpast_ff <= 1'b0;
               blo_ff <= '0;
               bhi_ff <= '0;
               bhit_ff <= '0;
               blo_bin_ff <= '0;
               bhi_bin_ff <= '0;
            end else if (both_ff) begin
               lvl_ff <= 1'b1;
               opm_ff <= tpos_ff - c_lo_ff;
               opd_ff <= (rv_ff >= a_ff) ? (rv_ff - a_ff) : (a_ff - rv_ff);
               neg_ff <= (rv_ff < a_ff);
               base_ff <= a_ff;
               div_ff <= c_hi_ff - c_lo_ff;
            end else begin
               rout_ff <= rv_ff;
            end
         end
         rmii_pkg::S_MUL: begin
            quo_ff <= (div_ff == '0) ? '0 : (PW'(opm_ff) * PW'(opd_ff));
            rem_ff <= '0;
            cnt_ff <= 6'(PW);
         end
         rmii_pkg::S_DIV: begin
            if (rem_ge) begin
               rem_ff <= CEN_W'(rem_sh - {1'b0, div_ff});
            end else begin
               rem_ff <= rem_sh[CEN_W-1:0];
            end
            quo_ff <= {quo_ff[PW-2:0], rem_ge};
            cnt_ff <= cnt_ff - 1'b1;
         end
         rmii_pkg::S_ADD: begin
            if (lvl_ff) begin
               rout_ff <= add_res;
            end else begin
               rv_ff <= add_res;
            end
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block stayed busy after its result beat");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not make the block busy");

   a_changed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_row_changed) |-> rsp_ok)
      else $error("row change reported without a placed value");

   a_lookup_only_ramp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_ok) |-> (rsp_ramp_out == '0))
      else $error("insert result carries a ramp value");

endmodule
